FILE: design/accm_pkg.sv
// Shared types, constants and AES helper functions for the CCM decrypt-and-verify block.
package accm_pkg;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_AUTH = 2'd1;
  localparam logic [1:0] ST_LEN  = 2'd2;

  localparam logic [7:0] CCM_FLAGS = 8'h0D;
  localparam int unsigned AES_LAST_ROUND = 14;

  typedef logic [127:0] blk_t;
  typedef logic [255:0] kwin_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic blk_t aes_round(input blk_t s, input logic final_round);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    blk_t r;
    for (int k = 0; k < 16; k++) begin
      b[k] = s[127 - 8 * k -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[i + 4 * c] = SBOX[b[i + 4 * ((c + i) % 4)]];
      end
    end
    if (!final_round) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4 * c];
        a1 = t[4 * c + 1];
        a2 = t[4 * c + 2];
        a3 = t[4 * c + 3];
        al = a0 ^ a1 ^ a2 ^ a3;
        t[4 * c]     = a0 ^ al ^ xtime(a0 ^ a1);
        t[4 * c + 1] = a1 ^ al ^ xtime(a1 ^ a2);
        t[4 * c + 2] = a2 ^ al ^ xtime(a2 ^ a3);
        t[4 * c + 3] = a3 ^ al ^ xtime(a3 ^ a0);
      end
    end
    for (int k = 0; k < 16; k++) begin
      r[127 - 8 * k -: 8] = t[k];
    end
    return r;
  endfunction

  // Advances an eight-word key window by four words.
  function automatic kwin_t key_step(input kwin_t kw, input logic rot, input logic [7:0] rcon);
    logic [31:0] t, w8, w9, w10, w11;
    if (rot) begin
      t = {SBOX[kw[23:16]] ^ rcon, SBOX[kw[15:8]], SBOX[kw[7:0]], SBOX[kw[31:24]]};
    end else begin
      t = {SBOX[kw[31:24]], SBOX[kw[23:16]], SBOX[kw[15:8]], SBOX[kw[7:0]]};
    end
    w8  = kw[255:224] ^ t;
    w9  = kw[223:192] ^ w8;
    w10 = kw[191:160] ^ w9;
    w11 = kw[159:128] ^ w10;
    return {kw[127:0], w8, w9, w10, w11};
  endfunction

  function automatic blk_t ccm_header(input logic [31:0] nu, input logic [63:0] nl,
                                      input logic [15:0] tail);
    return {CCM_FLAGS, nu, nl, 8'h00, tail};
  endfunction

  function automatic blk_t keep_mask(input logic [4:0] n);
    blk_t m;
    for (int k = 0; k < 16; k++) begin
      m[127 - 8 * k -: 8] = (5'(k) < n) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

FILE: design/accm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module accm_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/aes256_ccm_decrypt_verify.sv
// Top level of the AES-256 CCM-style decrypt-and-verify block.
//
// Ciphertext blocks arrive on the s_ channel (tuser high marks the tag item).
// Each block is stored and folded into the CBC-MAC; the tag item triggers the
// check and, on a match, the release of every plaintext block on the m_ channel.
// One AES round unit runs one round per cycle: an encryption loads the first
// round key, runs the rounds and ends in a finishing state. A ciphertext block
// takes one encryption, and the first block of a message also encrypts B0. A
// tag item takes an encryption for the check plus one for each plaintext
// block released; a tag for an empty message also encrypts B0. Receiver stalls
// hold back the release of each result.
// Errors give one result without any encryption.
// The input is not ready while an item is at work. The result register holds its
// item while m_tready is low, and the sequencer waits for it before loading more.
// Configuration writes are always accepted and must only be made while idle.
// Reset clears the configuration, the state, the MAC and the block count; the
// ciphertext store needs no clearing.
module aes256_ccm_decrypt_verify import accm_pkg::*; #(
  parameter int MAX_BLOCKS = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // block_high, block_low
  input  logic         s_tuser,   // is_tag
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata,   // text_high, text_low, valid_bytes, zero fill
  output logic         m_tlast,   // last
  output logic [1:0]   m_tuser,   // status
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int BW = $clog2(MAX_BLOCKS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ENC  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  localparam logic [1:0] P_B0  = 2'd0;
  localparam logic [1:0] P_MAC = 2'd1;
  localparam logic [1:0] P_A0  = 2'd2;
  localparam logic [1:0] P_CTR = 2'd3;

  localparam logic [2:0] R_KEY0  = 3'd0;
  localparam logic [2:0] R_KEY1  = 3'd1;
  localparam logic [2:0] R_KEY2  = 3'd2;
  localparam logic [2:0] R_KEY3  = 3'd3;
  localparam logic [2:0] R_NONCE_U = 3'd4;
  localparam logic [2:0] R_NONCE_L = 3'd5;
  localparam logic [2:0] R_LEN   = 3'd6;

  logic [63:0] key_word0, key_word1, key_word2, key_word3;
  logic [31:0] nonce_upper;
  logic [63:0] nonce_lower;
  logic [15:0] message_length;

  logic [1:0]    state;
  logic [1:0]    purp;
  logic [3:0]    rnd;
  blk_t          st;
  kwin_t         kw;
  logic [7:0]    rcon;
  blk_t          mac_chain;
  blk_t          blk;
  logic          tag_item;
  logic [BW-1:0] blocks_received;
  logic [AW-1:0] ctr;
  logic          pend_more;
  blk_t          pend_text;
  logic [4:0]    pend_valid;
  logic          pend_last;
  logic [1:0]    pend_status;

  logic [12:0]  needed;
  logic         too_long;
  logic         accept;
  logic [15:0]  rem_in;
  blk_t         in_masked;
  logic         data_ok;
  logic         tag_ok;
  logic         match;
  logic [15:0]  rem_c;
  logic [4:0]   keep_c;
  logic         last_c;
  logic         out_free;
  blk_t         ram_rdata;
  logic         ram_we;
  logic         start_en;
  blk_t         start_din;
  kwin_t        key;

  assign key       = {key_word0, key_word1, key_word2, key_word3};
  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  assign needed   = 13'((17'(message_length) + 17'd15) >> 4);
  assign too_long = needed > 13'(MAX_BLOCKS);
  assign rem_in   = message_length - 16'({blocks_received, 4'b0});
  assign in_masked = {s_tdata[63:0], s_tdata[127:64]} &
                     ((rem_in < 16'd16) ? keep_mask(rem_in[4:0]) : '1);
  assign data_ok  = !too_long && !s_tuser && (13'(blocks_received) < needed);
  assign tag_ok   = !too_long && s_tuser && (13'(blocks_received) == needed);
  assign match    = (st ^ mac_chain) == blk;
  assign rem_c    = message_length - 16'({ctr, 4'b0});
  assign keep_c   = (rem_c < 16'd16) ? rem_c[4:0] : 5'd16;
  assign last_c   = (13'(ctr) + 13'd1) == needed;
  assign ram_we   = accept && data_ok;

  accm_ram #(.WIDTH(128), .DEPTH(MAX_BLOCKS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (blocks_received[AW-1:0]),
    .wdata (in_masked),
    .raddr (ctr),
    .rdata (ram_rdata)
  );

  always_comb begin
    start_en  = 1'b0;
    start_din = '0;
    case (state)
      S_IDLE: begin
        if (accept && data_ok) begin
          start_en  = 1'b1;
          start_din = (blocks_received == '0) ?
                      ccm_header(nonce_upper, nonce_lower, message_length) :
                      (mac_chain ^ in_masked);
        end else if (accept && tag_ok) begin
          start_en  = 1'b1;
          start_din = ccm_header(nonce_upper, nonce_lower,
                                 (needed == '0) ? message_length : 16'd0);
        end
      end
      S_FIN: begin
        if (purp == P_B0) begin
          start_en  = 1'b1;
          start_din = tag_item ? ccm_header(nonce_upper, nonce_lower, 16'd0) : (st ^ blk);
        end else if (purp == P_A0 && match && needed != '0) begin
          start_en  = 1'b1;
          start_din = ccm_header(nonce_upper, nonce_lower, 16'd1);
        end
      end
      S_EMIT: begin
        if (out_free && pend_more) begin
          start_en  = 1'b1;
          start_din = ccm_header(nonce_upper, nonce_lower, 16'(ctr) + 16'd2);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_word0      <= '0;
      key_word1      <= '0;
      key_word2      <= '0;
      key_word3      <= '0;
      nonce_upper    <= '0;
      nonce_lower    <= '0;
      message_length <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        R_KEY0:    key_word0      <= cfg_data;
        R_KEY1:    key_word1      <= cfg_data;
        R_KEY2:    key_word2      <= cfg_data;
        R_KEY3:    key_word3      <= cfg_data;
        R_NONCE_U: nonce_upper    <= cfg_data[31:0];
        R_NONCE_L: nonce_lower    <= cfg_data;
        R_LEN:     message_length <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // Round unit: one AES round a cycle with the key schedule running alongside.
  always_ff @(posedge clk) begin
    if (start_en) begin
      st   <= start_din ^ key[255:128];
      kw   <= key_step(key, 1'b1, 8'h01);
      rcon <= 8'h02;
      rnd  <= 4'd1;
    end else if (state == S_ENC) begin
      st  <= aes_round(st, rnd == 4'(AES_LAST_ROUND)) ^ kw[255:128];
      kw  <= key_step(kw, !rnd[0], rcon);
      rnd <= rnd + 4'd1;
      if (!rnd[0]) begin
        rcon <= xtime(rcon);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      purp            <= P_B0;
      mac_chain       <= '0;
      blocks_received <= '0;
      ctr             <= '0;
      pend_more       <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_EMIT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            blk      <= s_tuser ? {s_tdata[63:0], s_tdata[127:64]} : in_masked;
            tag_item <= s_tuser;
            if (data_ok) begin
              state <= S_ENC;
              purp  <= (blocks_received == '0) ? P_B0 : P_MAC;
            end else if (tag_ok) begin
              state <= S_ENC;
              purp  <= (needed == '0) ? P_B0 : P_A0;
            end else begin
              blocks_received <= '0;
              pend_text       <= '0;
              pend_valid      <= '0;
              pend_last       <= 1'b1;
              pend_status     <= ST_LEN;
              pend_more       <= 1'b0;
              state           <= S_EMIT;
            end
          end
        end
        S_ENC: begin
          if (rnd == 4'(AES_LAST_ROUND)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          case (purp)
            P_B0: begin
              mac_chain <= st;
              purp      <= tag_item ? P_A0 : P_MAC;
              state     <= S_ENC;
            end
            P_MAC: begin
              mac_chain       <= st;
              blocks_received <= blocks_received + BW'(1);
              state           <= S_IDLE;
            end
            P_A0: begin
              blocks_received <= '0;
              ctr             <= '0;
              pend_text       <= '0;
              pend_valid      <= '0;
              pend_last       <= 1'b1;
              pend_more       <= 1'b0;
              pend_status     <= match ? ST_OK : ST_AUTH;
              if (match && needed != '0) begin
                purp  <= P_CTR;
                state <= S_ENC;
              end else begin
                state <= S_EMIT;
              end
            end
            default: begin
              pend_text   <= (st ^ ram_rdata) & keep_mask(keep_c);
              pend_valid  <= keep_c;
              pend_last   <= last_c;
              pend_status <= ST_OK;
              pend_more   <= !last_c;
              state       <= S_EMIT;
            end
          endcase
        end
        default: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {3'b000, pend_valid, pend_text[63:0], pend_text[127:64]};
            m_tlast  <= pend_last;
            m_tuser  <= pend_status;
            if (pend_more) begin
              ctr   <= ctr + AW'(1);
              state <= S_ENC;
            end else begin
              state <= S_IDLE;
            end
          end
        end
      endcase
    end
  end

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_OK) |-> m_tlast)
    else $error("error result without last");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_OK) |-> (m_tdata[132:0] == '0))
    else $error("error result carries text");

  a_count: assert property (@(posedge clk) disable iff (rst)
    32'(blocks_received) <= MAX_BLOCKS)
    else $error("block count beyond capacity");

  a_round: assert property (@(posedge clk) disable iff (rst)
    (state == S_ENC) |-> (rnd != 4'd0 && rnd <= 4'(AES_LAST_ROUND)))
    else $error("round counter out of range");

endmodule
